@@ hdl/lcdw_pkg.sv @@
package lcdw_pkg;

  // Request operations
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_CURSOR = 2'd1,
    OP_INIT   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] REG_ENABLE_PULSE = 2'd0;
  localparam logic [1:0] REG_NIBBLE_GAP   = 2'd1;
  localparam logic [1:0] REG_COMMAND_GAP  = 2'd2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Reset values of the configuration registers
  localparam logic [7:0]  ENABLE_PULSE_RST = 8'd1;
  localparam logic [15:0] NIBBLE_GAP_RST   = 16'd100;
  localparam logic [15:0] COMMAND_GAP_RST  = 16'd50;

  // Power-up waits in microseconds
  localparam logic [15:0] PWR_WAIT0_US = 16'd40000;
  localparam logic [15:0] PWR_WAIT1_US = 16'd5000;
  localparam logic [15:0] PWR_WAIT2_US = 16'd100;
  localparam logic [15:0] PWR_WAIT3_US = 16'd50;

  // Power-up nibbles
  localparam logic [3:0] NIB_FUNC8 = 4'h3;
  localparam logic [3:0] NIB_FUNC4 = 4'h2;

  // Cursor commands: first line 0x80, second line 0xC0
  localparam logic [1:0] CMD_DDRAM_HI = 2'b10;

  // Sequencer step counter
  localparam int unsigned  STEP_W    = 4;
  localparam logic [3:0]   BYTE_LAST = 4'd6;
  localparam logic [3:0]   INIT_LAST = 4'd12;

  // Queue depths
  localparam int unsigned QUEUE_DEPTH_DEF  = 2;
  localparam int unsigned RESULT_DEPTH_DEF = 2;

  typedef struct packed {
    logic [1:0] operation;
    logic       register_select;
    logic [7:0] data_byte;
    logic [4:0] position;
  } request_t;

  typedef struct packed {
    logic        rs_level;
    logic [3:0]  data_nibble;
    logic        enable_level;
    logic [15:0] hold_us;
    logic        last;
  } result_t;

  // Classified work handed from the front to the sequencer
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] byte_val;
  } job_t;

  // Timing configuration seen by the sequencer
  typedef struct packed {
    logic [7:0]  enable_pulse_us;
    logic [15:0] nibble_gap_us;
    logic [15:0] command_gap_us;
  } timing_t;

endpackage

@@ hdl/lcdw_fifo.sv @@
module lcdw_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/lcdw_front.sv @@
module lcdw_front (
  input  lcdw_pkg::request_t request,
  input  logic               push,
  input  logic               full,
  output logic               job_push,
  output lcdw_pkg::job_t     job
);

  logic       is_move;
  logic [7:0] cursor_cmd;

  // cursor command: 0x80 + pos on line one, 0xC0 + (pos - 16) on line two
  assign cursor_cmd = {lcdw_pkg::CMD_DDRAM_HI[1], request.position[4],
                       lcdw_pkg::CMD_DDRAM_HI[0], 1'b0, request.position[3:0]};

  assign is_move = (request.operation == lcdw_pkg::OP_CURSOR);

  // classify; unused operation is taken and dropped
  always_comb begin
    job.is_init  = (request.operation == lcdw_pkg::OP_INIT);
    job.rs       = is_move ? 1'b0 : request.register_select;
    job.byte_val = is_move ? cursor_cmd : request.data_byte;
    job_push     = push && !full && (request.operation != lcdw_pkg::OP_NONE);
  end

endmodule

@@ hdl/lcdw_seq.sv @@
module lcdw_seq (
  input  logic              clk,
  input  logic              rst,
  input  lcdw_pkg::timing_t timing,
  input  logic              job_empty,
  input  lcdw_pkg::job_t    job,
  output logic              job_pop,
  input  logic              res_full,
  output logic              res_push,
  output lcdw_pkg::result_t res
);

  logic                        busy;
  lcdw_pkg::job_t              cur;
  logic [lcdw_pkg::STEP_W-1:0] step;

  logic        fire;
  logic        last_ev;
  logic        can_load;
  logic [3:0]  nib;
  logic [15:0] extra;
  logic [16:0] gap_sum;
  logic [15:0] gap_sat;

  assign fire     = busy && !res_full;
  assign last_ev  = cur.is_init ? (step == lcdw_pkg::INIT_LAST)
                                : (step == lcdw_pkg::BYTE_LAST);
  assign can_load = !busy || (fire && last_ev);
  assign job_pop  = can_load && !job_empty;
  assign res_push = fire;

  // power-up wait that follows each gap event
  always_comb begin
    case (step)
      4'd3:        extra = lcdw_pkg::PWR_WAIT1_US;
      4'd6:        extra = lcdw_pkg::PWR_WAIT2_US;
      4'd9, 4'd12: extra = lcdw_pkg::PWR_WAIT3_US;
      default:     extra = '0;
    endcase
  end

  // nibble gap plus power-up wait, saturated
  assign gap_sum = {1'b0, timing.nibble_gap_us} + {1'b0, extra};
  assign gap_sat = gap_sum[16] ? 16'hFFFF : gap_sum[15:0];

  // event decode for the current step
  always_comb begin
    nib              = (step < 4'd3) ? cur.byte_val[7:4] : cur.byte_val[3:0];
    res.rs_level     = cur.rs;
    res.enable_level = 1'b0;
    res.hold_us      = {8'd0, timing.enable_pulse_us};
    res.last         = last_ev;
    if (cur.is_init) begin
      res.rs_level = 1'b0;
      nib          = (step >= 4'd10) ? lcdw_pkg::NIB_FUNC4 : lcdw_pkg::NIB_FUNC8;
      case (step)
        4'd0: begin
          nib         = 4'h0;
          res.hold_us = lcdw_pkg::PWR_WAIT0_US;
        end
        4'd2, 4'd5, 4'd8, 4'd11: res.enable_level = 1'b1;
        4'd3, 4'd6, 4'd9, 4'd12: res.hold_us = gap_sat;
        default: ;
      endcase
    end else begin
      case (step)
        4'd1, 4'd4: res.enable_level = 1'b1;
        4'd2, 4'd5: res.hold_us = timing.nibble_gap_us;
        4'd6: begin
          res.rs_level = 1'b0;
          res.hold_us  = timing.command_gap_us;
        end
        default: ;
      endcase
    end
    res.data_nibble = nib;
  end

  // step through the job, load the next one as the last event leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (can_load) begin
      busy <= !job_empty;
      step <= '0;
    end else if (fire) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
  end

  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    busy && !cur.is_init |-> step <= lcdw_pkg::BYTE_LAST)
    else $error("byte sequence ran past its closing event");

  a_init_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= lcdw_pkg::INIT_LAST)
    else $error("power-up sequence ran past its last event");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    !busy |-> step == '0)
    else $error("step counter not cleared while idle");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    fire && last_ev |=> step == '0)
    else $error("step counter not restarted after last event");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    busy && res_full |=> busy && $stable(step))
    else $error("sequencer advanced while result queue full");

endmodule

@@ hdl/lcd_4bit_write_sequencer_core.sv @@
// Four-bit character LCD write sequencer.
// Requests enter through a queue-like port: an item is taken at a clock edge
// with push high and full low. Each request becomes a list of pin events
// (RS level, D7..D4 nibble, E level, hold time in microseconds), the final
// one marked by last. Events leave through a queue-like port: the oldest is
// shown while empty is low and is taken at an edge with pop high.
// A byte write or cursor move gives 7 events, power-up gives 13; an unused
// operation is taken and gives none. Events are produced one per cycle
// while the result queue is not full; the next request starts in the cycle
// after the previous last event. An item passes the job queue and the
// sequencer's current-job register; its events then pass the result queue.
// A small job queue lets new requests be taken while one is being played.
// When pop stays low the result queue fills, the sequencer holds its step
// and the job queue fills behind it, after which full rises.
// The user must write timing registers through wr_en / wr_index / wr_data
// only while idle; the block does not enforce it. Synchronous reset empties
// both queues, stops the sequencer, sets timing to 1, 100, 50 microseconds.
module lcd_4bit_write_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH  = lcdw_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned RESULT_DEPTH = lcdw_pkg::RESULT_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  lcdw_pkg::request_t                  request,
  output logic                                empty,
  input  logic                                pop,
  output lcdw_pkg::result_t                   result,
  input  logic                                wr_en,
  input  logic [lcdw_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [lcdw_pkg::CFG_DATA_W-1:0]     wr_data
);

  lcdw_pkg::timing_t timing;
  lcdw_pkg::job_t    job_in;
  lcdw_pkg::job_t    job_out;
  lcdw_pkg::result_t res;
  logic              job_push;
  logic              job_pop;
  logic              job_empty;
  logic              res_push;
  logic              res_full;
  logic [$bits(lcdw_pkg::job_t)-1:0]    job_rdata;
  logic [$bits(lcdw_pkg::result_t)-1:0] res_rdata;

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.enable_pulse_us <= lcdw_pkg::ENABLE_PULSE_RST;
      timing.nibble_gap_us   <= lcdw_pkg::NIBBLE_GAP_RST;
      timing.command_gap_us  <= lcdw_pkg::COMMAND_GAP_RST;
    end else if (wr_en) begin
      case (wr_index)
        lcdw_pkg::REG_ENABLE_PULSE: timing.enable_pulse_us <= wr_data[7:0];
        lcdw_pkg::REG_NIBBLE_GAP:   timing.nibble_gap_us   <= wr_data;
        lcdw_pkg::REG_COMMAND_GAP:  timing.command_gap_us  <= wr_data;
        default: ;
      endcase
    end
  end

  // front: take and classify requests
  lcdw_front u_front (
    .request  (request),
    .push     (push),
    .full     (full),
    .job_push (job_push),
    .job      (job_in)
  );

  // job queue between front and sequencer
  lcdw_fifo #(
    .WIDTH ($bits(lcdw_pkg::job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  assign job_out = job_rdata;

  // back: play out pin events
  lcdw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .timing    (timing),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue towards the consumer
  lcdw_fifo #(
    .WIDTH ($bits(lcdw_pkg::result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign result = res_rdata;

endmodule
